@@ rtl/trpn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpn_pkg
// Shared widths and command/status codes for the typed RPN stack unit.
// ----------------------------------------------------------------------------
package trpn_pkg;

  localparam int StackDepth = 64;
  localparam int PtrW       = $clog2(StackDepth);
  localparam int CntW       = $clog2(StackDepth + 1);
  localparam int DataW      = 32;
  localparam int EntryW     = DataW + 1;

  typedef logic [4:0]        cmd_t;
  typedef logic [2:0]        status_t;
  typedef logic [DataW-1:0]  data_t;
  typedef logic [EntryW-1:0] entry_t;
  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [PtrW-1:0]   ptr_t;

  localparam cmd_t CMD_PUSH_INT  = 5'd0;
  localparam cmd_t CMD_PUSH_BOOL = 5'd1;
  localparam cmd_t CMD_NOT       = 5'd2;
  localparam cmd_t CMD_PRINT     = 5'd3;
  localparam cmd_t CMD_CLEAR     = 5'd4;
  localparam cmd_t CMD_DROP      = 5'd5;
  localparam cmd_t CMD_DUP       = 5'd6;
  localparam cmd_t CMD_SWAP      = 5'd7;
  localparam cmd_t CMD_ADD       = 5'd8;
  localparam cmd_t CMD_SUB       = 5'd9;
  localparam cmd_t CMD_MUL       = 5'd10;
  localparam cmd_t CMD_DIV       = 5'd11;
  localparam cmd_t CMD_MOD       = 5'd12;
  localparam cmd_t CMD_LT        = 5'd13;
  localparam cmd_t CMD_GT        = 5'd14;
  localparam cmd_t CMD_LE        = 5'd15;
  localparam cmd_t CMD_GE        = 5'd16;
  localparam cmd_t CMD_EQ        = 5'd17;

  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_EMPTY = 3'd1;
  localparam status_t ST_TYPE  = 3'd2;
  localparam status_t ST_DIV0  = 3'd3;
  localparam status_t ST_FULL  = 3'd4;

endpackage

@@ rtl/typed_rpn_evaluation_stack_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_rpn_evaluation_stack_unit
// Stack of tagged int/bool entries driven by one command per input beat.
// ----------------------------------------------------------------------------
// One command is taken at a time; its result beat sits in an output register.
// Push, clear, drop and unused codes finish in the first step; print, not and
// dup also read the top entry; swap, eq, add, sub, mul and compares also read
// a second entry (one registered memory read port, one ALU stage). Div and mod
// use the shared radix-2 divider in place of the ALU stage. Empty, type and
// full errors finish early; a zero divisor runs the whole division, pushes
// zero and reports div0. A new command is taken only after the result beat
// has left. No clearing pass after reset.
module typed_rpn_evaluation_stack_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  trpn_pkg::cmd_t        in_cmd,
  input  logic signed [31:0]    in_literal,
  output logic                  out_valid,
  input  logic                  out_stall,
  output trpn_pkg::status_t     out_status,
  output logic                  out_print_valid,
  output logic                  out_print_is_bool,
  output logic signed [31:0]    out_print_value,
  output logic [6:0]            out_depth_now
);
  import trpn_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA  = 4'd1;
  localparam logic [3:0] S_GOTA = 4'd2;
  localparam logic [3:0] S_GOTB = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_ALU  = 4'd5;
  localparam logic [3:0] S_PUSH = 4'd6;
  localparam logic [3:0] S_PUSH2 = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_r, state_nxt;
  cmd_t       cmd_r;
  data_t      lit_r;
  cnt_t       cnt_r, cnt_nxt;
  entry_t     a_r, b_r;
  entry_t     wr1_r;
  status_t    st_r, st_nxt;
  logic       pv_r, pv_nxt;
  logic       obusy_r;

  entry_t     mem [StackDepth];
  entry_t     rd_q;
  ptr_t       top_ptr;
  ptr_t       rd_addr;
  logic       we;
  ptr_t       wa;
  entry_t     wd;

  // divider
  logic [5:0]  dcnt_r;
  logic [31:0] dq_r, dd_r;
  logic [32:0] drem_r;
  logic        dnq_r, dnr_r;
  logic [32:0] dtrial;

  logic [31:0] ua, ub;
  assign ua = a_r[31] ? (~a_r[31:0] + 32'd1) : a_r[31:0];
  assign ub = b_r[31] ? (~b_r[31:0] + 32'd1) : b_r[31:0];
  assign dtrial = {drem_r[31:0], dq_r[31]} - {1'b0, dd_r};

  // second entry is fetched while the top entry is consumed
  assign top_ptr = cnt_r[PtrW-1:0] - ptr_t'(1);
  assign rd_addr = (state_r == S_GOTA) ? (top_ptr - ptr_t'(1)) : top_ptr;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[rd_addr];
  end

  logic signed [31:0] sa, sb;
  assign sa = a_r[31:0];
  assign sb = b_r[31:0];
  logic ltv, eqv;
  assign ltv = sb < sa;
  assign eqv = sb == sa;

  logic full;
  assign full = cnt_r == cnt_t'(StackDepth);

  assign in_stall = (state_r != S_IDLE) || obusy_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    st_nxt    = st_r;
    pv_nxt    = pv_r;
    we = 1'b0;
    wa = cnt_r[PtrW-1:0];
    wd = wr1_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) state_nxt = S_RDA;
      end
      S_RDA: begin
        st_nxt = ST_OK;
        pv_nxt = 1'b0;
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_PUSH_INT, CMD_PUSH_BOOL: begin
            if (full) st_nxt = ST_FULL;
            else begin
              we = 1'b1;
              wd = (cmd_r == CMD_PUSH_INT) ? {1'b0, lit_r} : {1'b1, 31'd0, lit_r[0]};
              cnt_nxt = cnt_r + cnt_t'(1);
            end
          end
          CMD_CLEAR: cnt_nxt = '0;
          CMD_DROP: begin
            if (cnt_r == '0) st_nxt = ST_EMPTY;
            else cnt_nxt = cnt_r - cnt_t'(1);
          end
          CMD_PRINT, CMD_NOT, CMD_DUP, CMD_SWAP, CMD_ADD, CMD_SUB, CMD_MUL,
          CMD_DIV, CMD_MOD, CMD_LT, CMD_GT, CMD_LE, CMD_GE, CMD_EQ: begin
            if (cnt_r == '0) st_nxt = ST_EMPTY;
            else state_nxt = S_GOTA;
          end
          default: ;
        endcase
      end
      S_GOTA: begin
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_PRINT: pv_nxt = 1'b1;
          CMD_DUP: begin
            if (full) st_nxt = ST_FULL;
            else begin
              we = 1'b1; wd = rd_q; cnt_nxt = cnt_r + cnt_t'(1);
            end
          end
          CMD_NOT: begin
            cnt_nxt = cnt_r - cnt_t'(1);
            if (!rd_q[32]) st_nxt = ST_TYPE;
            else begin
              we = 1'b1; wa = top_ptr; wd = {1'b1, 31'd0, ~rd_q[0]};
              cnt_nxt = cnt_r;
            end
          end
          CMD_SWAP, CMD_EQ: begin
            cnt_nxt = cnt_r - cnt_t'(1);
            if (cnt_r == cnt_t'(1)) st_nxt = ST_EMPTY;
            else state_nxt = S_GOTB;
          end
          default: begin
            if (rd_q[32]) st_nxt = ST_TYPE;
            else begin
              cnt_nxt = cnt_r - cnt_t'(1);
              if (cnt_r == cnt_t'(1)) st_nxt = ST_EMPTY;
              else state_nxt = S_GOTB;
            end
          end
        endcase
      end
      S_GOTB: begin
        if (cmd_r == CMD_SWAP || cmd_r == CMD_EQ) begin
          cnt_nxt = cnt_r - cnt_t'(1);
          state_nxt = (cmd_r == CMD_SWAP) ? S_PUSH2 : S_ALU;
        end else if (rd_q[32]) begin
          st_nxt = ST_TYPE;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - cnt_t'(1);
          state_nxt = (cmd_r == CMD_DIV || cmd_r == CMD_MOD) ? S_DIV : S_ALU;
        end
      end
      S_DIV: begin
        if (dcnt_r == 6'd33) state_nxt = S_PUSH;
      end
      S_ALU: state_nxt = S_PUSH;
      S_PUSH: begin
        we = 1'b1; wd = wr1_r; cnt_nxt = cnt_r + cnt_t'(1);
        if ((cmd_r == CMD_DIV || cmd_r == CMD_MOD) && a_r[31:0] == '0) st_nxt = ST_DIV0;
        state_nxt = S_DONE;
      end
      S_PUSH2: begin
        we = 1'b1; wd = a_r; cnt_nxt = cnt_r + cnt_t'(1);
        state_nxt = S_PUSH;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      obusy_r <= 1'b0;
      st_r    <= ST_OK;
      pv_r    <= 1'b0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      st_r    <= st_nxt;
      pv_r    <= pv_nxt;
      if (state_r == S_DONE) obusy_r <= 1'b1;
      else if (!out_stall) obusy_r <= 1'b0;
      if (state_r == S_GOTB) dcnt_r <= '0;
      else if (state_r == S_DIV) dcnt_r <= dcnt_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      cmd_r <= in_cmd;
      lit_r <= in_literal;
    end
    if (state_r == S_GOTA) a_r <= rd_q;
    if (state_r == S_GOTB) begin
      b_r <= rd_q;
      wr1_r <= rd_q;
    end
    if (state_r == S_DIV) begin
      if (dcnt_r == 6'd0) begin
        dq_r <= ub; dd_r <= ua; drem_r <= '0;
        dnq_r <= a_r[31] ^ b_r[31]; dnr_r <= b_r[31];
      end else if (dcnt_r <= 6'd32) begin
        if (!dtrial[32]) begin
          drem_r <= dtrial; dq_r <= {dq_r[30:0], 1'b1};
        end else begin
          drem_r <= {drem_r[31:0], dq_r[31]}; dq_r <= {dq_r[30:0], 1'b0};
        end
      end else begin
        if (a_r[31:0] == '0) wr1_r <= '0;
        else if (cmd_r == CMD_DIV)
          wr1_r <= {1'b0, dnq_r ? (~dq_r + 32'd1) : dq_r};
        else wr1_r <= {1'b0, dnr_r ? (~drem_r[31:0] + 32'd1) : drem_r[31:0]};
      end
    end
    if (state_r == S_ALU) begin
      case (cmd_r)
        CMD_ADD: wr1_r <= {1'b0, b_r[31:0] + a_r[31:0]};
        CMD_SUB: wr1_r <= {1'b0, b_r[31:0] - a_r[31:0]};
        CMD_MUL: wr1_r <= {1'b0, b_r[31:0] * a_r[31:0]};
        CMD_LT:  wr1_r <= {1'b1, 31'd0, ltv};
        CMD_GT:  wr1_r <= {1'b1, 31'd0, !ltv && !eqv};
        CMD_LE:  wr1_r <= {1'b1, 31'd0, ltv || eqv};
        CMD_GE:  wr1_r <= {1'b1, 31'd0, !ltv};
        CMD_EQ:  wr1_r <= {1'b1, 31'd0, a_r == b_r};
        default: wr1_r <= wr1_r;
      endcase
    end
  end

  assign out_valid         = obusy_r;
  assign out_status        = st_r;
  assign out_print_valid   = pv_r;
  assign out_print_is_bool = pv_r & a_r[32];
  assign out_print_value   = pv_r ? a_r[31:0] : 32'd0;
  assign out_depth_now     = 7'(cnt_r);

endmodule

@@ rtl/trpn_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpn_checker
// Port-level checks for the typed RPN stack unit.
// ----------------------------------------------------------------------------
module trpn_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input trpn_pkg::status_t out_status,
  input logic              out_print_valid,
  input logic [6:0]        out_depth_now
);
  import trpn_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while busy");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_depth_now <= 7'd64)
    else $error("depth out of range");

  a_print: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_print_valid |-> out_status == ST_OK)
    else $error("print with error status");

endmodule

bind typed_rpn_evaluation_stack_unit trpn_checker u_trpn_checker (.*);
